// ===== hdl/rau_pkg.sv =====
// Shared constants and types for the rational arithmetic unit.
package rau_pkg;
   localparam int WordBits = 32;
   localparam int ProdBits = 2 * WordBits;
   localparam int CntBits = $clog2(ProdBits + 1);

   localparam logic [1:0] OP_SUB = 2'd0;
   localparam logic [1:0] OP_NEG = 2'd1;
   localparam logic [1:0] OP_DIV = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [31:0] a_num;
      logic [31:0] a_den;
      logic [31:0] b_num;
      logic [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic [31:0] res_num;
      logic [30:0] res_den;
      logic [1:0] status;
   } rsp_type;
endpackage

// ===== hdl/rau_if.sv =====
// Valid/ready channel interface.
interface rau_req_if;
   logic valid;
   logic ready;
   rau_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
   logic valid;
   logic ready;
   rau_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rational_arith_unit.sv =====
// Top level of the rational arithmetic unit: bit-serial multiply, gcd and divide.
//
// Usage: a request on req (op, a_num, a_den, b_num, b_den) gives one response on
// rsp (res_num, res_den, status). op 0 is a - b, 1 (and 3) is -a, 2 is a / b.
// Handshake: a transfer happens on an edge with valid and ready high.
// Sequencing: one request at a time. Error cases go from the check state straight
// to the output state, which raises rsp.valid. Otherwise the work is: two 32x32
// shift-add multiplies run in parallel (subtract needs a third product, in a second
// pass; negation skips the multiplies), a binary gcd that shifts or subtracts one
// step per cycle, and two restoring divisions by the gcd run side by side, one
// quotient bit per cycle. A zero result skips the gcd and the divide.
// Throughput: the next request is accepted from the cycle after the response is taken.
// The gcd subtract/compare on 64 bits sets the cycle time.
// Reset: synchronous, active high, returns the sequencer to idle, drops rsp.valid.
// Stall: the finished response is held in the output register until taken;
// req.ready stays low until then.
module rational_arith_unit (
   input logic clock,
   input logic reset,
   rau_req_if.sink req,
   rau_rsp_if.source rsp
);
   localparam int W = rau_pkg::WordBits;
   localparam int P = rau_pkg::ProdBits;
   localparam int C = rau_pkg::CntBits;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001, S_CHECK = 9'b000000010, S_MUL1 = 9'b000000100,
      S_MUL2 = 9'b000001000, S_PREP = 9'b000010000, S_GCD = 9'b000100000,
      S_DIV  = 9'b001000000, S_FIN  = 9'b010000000, S_OUT = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] op_ff;
   logic signed [W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   // multiplier: two lanes, each with its own accumulator and shifted multiplicand
   logic [P-1:0] acc0_ff, acc1_ff, mc0_ff, mc1_ff;
   logic [W-1:0] mp0_ff, mp1_ff;
   logic [C-1:0] cnt_ff;
   logic [P-1:0] t0_ff;                 // first product of subtract
   logic neg_ff;
   logic [P-1:0] mn_ff, md_ff, gx_ff, gy_ff;
   logic [C-1:0] k_ff;
   logic [P-1:0] q0_ff, q1_ff, r0_ff, r1_ff, g_ff;
   rau_pkg::rsp_type out_ff;
   logic out_v_ff;

   assign req.ready = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp.valid = out_v_ff;
   assign rsp.data = out_ff;

   wire req_fire = req.valid && req.ready;
   wire rsp_fire = out_v_ff && rsp.ready;

   wire neg_op = op_ff[0];
   wire [P-1:0] diff = t0_ff - acc1_ff;  // an*bd - bn*ad
   wire [P-1:0] n_sel = neg_op ? ~P'(signed'(an_ff)) + P'(1) :
                        (op_ff == rau_pkg::OP_SUB) ? diff : acc0_ff;
   wire [P-1:0] d_sel = neg_op ? P'(signed'(ad_ff)) :
                        (op_ff == rau_pkg::OP_SUB) ? acc0_ff : acc1_ff;
   wire [P-1:0] lim = P'((64'd1 << (W - 1)) - 64'd1);
   wire [P-1:0] rem0 = {r0_ff[P-2:0], q0_ff[P-1]};
   wire [P-1:0] rem1 = {r1_ff[P-2:0], q1_ff[P-1]};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_fire) state_in = S_CHECK;
         S_CHECK: begin
            if (ad_ff == '0 || (!neg_op && bd_ff == '0) ||
                (op_ff == rau_pkg::OP_DIV && bn_ff == '0) || neg_op)
               state_in = neg_op && ad_ff != '0 ? S_PREP : S_OUT;
            else
               state_in = S_MUL1;
         end
         S_MUL1: if (cnt_ff == C'(W - 1))
            state_in = (op_ff == rau_pkg::OP_SUB) ? S_MUL2 : S_PREP;
         S_MUL2: if (cnt_ff == C'(W - 1)) state_in = S_PREP;
         S_PREP: state_in = (n_sel == '0) ? S_OUT : S_GCD;
         S_GCD: if (gy_ff == '0) state_in = S_DIV;
         S_DIV: if (cnt_ff == C'(P - 1)) state_in = S_FIN;
         S_FIN: state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_fire) out_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_fire) begin
               op_ff <= req.data.op;
               an_ff <= req.data.a_num[W-1:0];
               ad_ff <= req.data.a_den[W-1:0];
               bn_ff <= req.data.b_num[W-1:0];
               bd_ff <= req.data.b_den[W-1:0];
            end
            S_CHECK: begin
               cnt_ff <= '0;
               acc0_ff <= '0;
               acc1_ff <= '0;
               // first pass: an*bd and (sub: ad*bd ; div: ad*bn)
               mc0_ff <= P'(signed'(an_ff));
               mp0_ff <= bd_ff;
               mc1_ff <= P'(signed'(ad_ff));
               mp1_ff <= (op_ff == rau_pkg::OP_DIV) ? bn_ff : bd_ff;
               out_ff.res_num <= '0;
               out_ff.res_den <= '0;
               if (ad_ff == '0 || (!neg_op && bd_ff == '0))
                  out_ff.status <= rau_pkg::ST_ZERO_DEN;
               else if (op_ff == rau_pkg::OP_DIV && bn_ff == '0)
                  out_ff.status <= rau_pkg::ST_DIV_ZERO;
               else
                  out_ff.status <= rau_pkg::ST_OK;
            end
            S_MUL1, S_MUL2: begin
               if (state_ff == S_MUL1 && cnt_ff == C'(W - 1) &&
                   op_ff == rau_pkg::OP_SUB) begin
                  // keep an*bd (finalized) and ad*bd; then bn*ad into acc1
                  t0_ff <= mp0_ff[0] ? acc0_ff - mc0_ff : acc0_ff;
                  acc0_ff <= mp1_ff[0] ? acc1_ff - mc1_ff : acc1_ff;
                  acc1_ff <= '0;
                  mc1_ff <= P'(signed'(bn_ff));
                  mp1_ff <= ad_ff;
                  mp0_ff <= '0;
                  cnt_ff <= '0;
               end else begin
                  // signed shift-add; top multiplier bit carries negative weight
                  if (cnt_ff == C'(W - 1)) begin
                     if (mp0_ff[0]) acc0_ff <= acc0_ff - mc0_ff;
                     if (mp1_ff[0]) acc1_ff <= acc1_ff - mc1_ff;
                  end else begin
                     if (mp0_ff[0]) acc0_ff <= acc0_ff + mc0_ff;
                     if (mp1_ff[0]) acc1_ff <= acc1_ff + mc1_ff;
                  end
                  mc0_ff <= mc0_ff << 1;
                  mc1_ff <= mc1_ff << 1;
                  mp0_ff <= mp0_ff >> 1;
                  mp1_ff <= mp1_ff >> 1;
                  cnt_ff <= cnt_ff + C'(1);
               end
            end
            S_PREP: begin
               neg_ff <= n_sel[P-1] ^ d_sel[P-1];
               mn_ff <= n_sel[P-1] ? ~n_sel + P'(1) : n_sel;
               md_ff <= d_sel[P-1] ? ~d_sel + P'(1) : d_sel;
               gx_ff <= n_sel[P-1] ? ~n_sel + P'(1) : n_sel;
               gy_ff <= d_sel[P-1] ? ~d_sel + P'(1) : d_sel;
               k_ff <= '0;
               if (n_sel == '0) begin
                  out_ff.res_num <= '0;
                  out_ff.res_den <= 31'd1;
                  out_ff.status <= rau_pkg::ST_OK;
               end
            end
            S_GCD: begin
               // one shift or subtract per cycle; x kept odd after common twos
               if (!gx_ff[0] && !gy_ff[0] && gy_ff != '0) begin
                  gx_ff <= gx_ff >> 1;
                  gy_ff <= gy_ff >> 1;
                  k_ff <= k_ff + C'(1);
               end else if (!gx_ff[0]) begin
                  gx_ff <= gx_ff >> 1;
               end else if (gy_ff != '0 && !gy_ff[0]) begin
                  gy_ff <= gy_ff >> 1;
               end else if (gy_ff != '0) begin
                  if (gx_ff > gy_ff) begin
                     gx_ff <= gy_ff;
                     gy_ff <= gx_ff - gy_ff;
                  end else begin
                     gy_ff <= gy_ff - gx_ff;
                  end
               end
               if (gy_ff == '0) begin
                  g_ff <= gx_ff << k_ff;
                  q0_ff <= mn_ff;
                  q1_ff <= md_ff;
                  r0_ff <= '0;
                  r1_ff <= '0;
                  cnt_ff <= '0;
               end
            end
            S_DIV: begin
               // restoring division, one quotient bit per cycle, two lanes
               if (rem0 >= g_ff) begin
                  r0_ff <= rem0 - g_ff;
                  q0_ff <= {q0_ff[P-2:0], 1'b1};
               end else begin
                  r0_ff <= rem0;
                  q0_ff <= {q0_ff[P-2:0], 1'b0};
               end
               if (rem1 >= g_ff) begin
                  r1_ff <= rem1 - g_ff;
                  q1_ff <= {q1_ff[P-2:0], 1'b1};
               end else begin
                  r1_ff <= rem1;
                  q1_ff <= {q1_ff[P-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + C'(1);
            end
            S_FIN: begin
               if (q1_ff > lim || q0_ff > lim + P'(neg_ff)) begin
                  out_ff.res_num <= '0;
                  out_ff.res_den <= '0;
                  out_ff.status <= rau_pkg::ST_OVERFLOW;
               end else begin
                  out_ff.res_num <= neg_ff ? 32'(~q0_ff + P'(1)) : 32'(q0_ff);
                  out_ff.res_den <= 31'(q1_ff);
                  out_ff.status <= rau_pkg::ST_OK;
               end
            end
            S_OUT: out_v_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> state_ff == S_IDLE && !out_v_ff) else $error("accept while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp.ready |=> out_v_ff && $stable(out_ff)) else $error("rsp dropped");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.status != rau_pkg::ST_OK |-> out_ff.res_den == '0)
      else $error("error with den");
   a_ok_den: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && out_ff.status == rau_pkg::ST_OK |-> out_ff.res_den != '0)
      else $error("zero den on ok");
endmodule

// ===== sim/tb_rau_if.sv =====
// Result record type shared by the testbench.
package tb_rau_types;
   typedef struct {
      logic [31:0] num;
      logic [30:0] den;
      logic [1:0] status;
   } frac_result_type;
endpackage

// ===== sim/tb_top.sv =====
// Self-checking testbench for the rational arithmetic unit: random and directed fractions.
module tb_top;
   logic clock = 1'b0;
   logic reset = 1'b1;

   rau_req_if req ();
   rau_rsp_if rsp ();

   rational_arith_unit dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   always #5 clock = ~clock;

   // requests waiting to be driven, and expected fractions in arrival order
   rau_pkg::req_type pending_reqs[$];
   tb_rau_types::frac_result_type expected_fracs[$];

   int unsigned mismatches = 0;
   int unsigned send_idle_pct = 27;   // sender idle chance, percent
   int unsigned recv_idle_pct = 50;   // receiver stall chance, percent
   bit hold_sender = 1'b0;            // pause until the pipe drains
   logic req_taken = 1'b0;            // request accepted at the last rising edge

   // binary gcd on magnitudes
   function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
      int k;
      longint unsigned t;
      k = 0;
      if (x == 0) return y;
      if (y == 0) return x;
      while (((x | y) & 1) == 0) begin
         x >>= 1;
         y >>= 1;
         k++;
      end
      while ((x & 1) == 0) x >>= 1;
      while (y != 0) begin
         while ((y & 1) == 0) y >>= 1;
         if (x > y) begin
            t = x;
            x = y;
            y = t;
         end
         y -= x;
      end
      return x << k;
   endfunction

   // exact fraction arithmetic with reduction and range check
   function automatic tb_rau_types::frac_result_type reduce_fraction(rau_pkg::req_type r);
      tb_rau_types::frac_result_type f;
      longint an, ad, bn, bd, n, d;
      longint unsigned mn, md, g, lim;
      bit is_neg, neg_op;
      an = longint'($signed(r.a_num));
      ad = longint'($signed(r.a_den));
      bn = longint'($signed(r.b_num));
      bd = longint'($signed(r.b_den));
      neg_op = r.op[0];
      f.num = '0;
      f.den = '0;
      if (ad == 0 || (!neg_op && bd == 0)) begin
         f.status = rau_pkg::ST_ZERO_DEN;
         return f;
      end
      if (r.op == rau_pkg::OP_DIV && bn == 0) begin
         f.status = rau_pkg::ST_DIV_ZERO;
         return f;
      end
      if (neg_op) begin
         n = -an;
         d = ad;
      end else if (r.op == rau_pkg::OP_SUB) begin
         n = an * bd - bn * ad;
         d = ad * bd;
      end else begin
         n = an * bd;
         d = ad * bn;
      end
      f.status = rau_pkg::ST_OK;
      if (n == 0) begin
         f.den = 31'd1;
         return f;
      end
      is_neg = (n < 0) != (d < 0);
      mn = (n < 0) ? longint'(0) - n : n;
      md = (d < 0) ? longint'(0) - d : d;
      g = gcd64(mn, md);
      mn /= g;
      md /= g;
      lim = (64'd1 << (rau_pkg::WordBits - 1)) - 1;
      if (md > lim || mn > lim + (is_neg ? 1 : 0)) begin
         f.status = rau_pkg::ST_OVERFLOW;
         return f;
      end
      f.num = is_neg ? 32'(-mn) : 32'(mn);
      f.den = 31'(md);
      return f;
   endfunction

   // operand picks: extremes, small values and full-range values
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'd0;
         4, 5: return 32'($signed($urandom_range(0, 40)) - 20);
         6: return 32'($urandom_range(0, 65535)) * 32'($urandom_range(1, 7));
         default: return $urandom;
      endcase
   endfunction

   function automatic void queue_req(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                                     logic [31:0] bn, logic [31:0] bd);
      rau_pkg::req_type r;
      r.op = op;
      r.a_num = an;
      r.a_den = ad;
      r.b_num = bn;
      r.b_den = bd;
      pending_reqs = {pending_reqs, r};
   endfunction

   // driver: new request offered at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.data <= '0;
      end else if (req.valid && !req_taken) begin
         // hold current request
      end else if (!hold_sender && pending_reqs.size() > 0
                   && $urandom_range(0, 99) >= send_idle_pct) begin
         req.valid <= 1'b1;
         req.data <= pending_reqs.pop_front();
      end else begin
         req.valid <= 1'b0;
      end
      rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      tb_rau_types::frac_result_type want;
      req_taken <= !reset && req.valid && req.ready;
      if (!reset) begin
         if (req.valid && req.ready)
            expected_fracs = {expected_fracs, reduce_fraction(req.data)};
         if (rsp.valid && rsp.ready) begin
            if (expected_fracs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp.data);
            end else begin
               want = expected_fracs.pop_front();
               if (rsp.data.res_num !== want.num || rsp.data.res_den !== want.den
                   || rsp.data.status !== want.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                              $signed(want.num), want.den, want.status,
                              $signed(rsp.data.res_num), rsp.data.res_den,
                              rsp.data.status);
               end
            end
         end
      end
   end

   function automatic void queue_random(int count);
      logic [1:0] op;
      for (int i = 0; i < count; i++) begin
         op = 2'($urandom_range(0, 3));
         queue_req(op, pick_word(), pick_word(), pick_word(), pick_word());
      end
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || req.valid || expected_fracs.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: every op, error cases, zero result, extremes, overflow
      queue_req(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd3);
      queue_req(rau_pkg::OP_NEG, 32'd3, 32'hffff_fffa, 32'd0, 32'd0);
      queue_req(rau_pkg::OP_DIV, 32'd2, 32'd3, 32'hffff_fffc, 32'd9);
      queue_req(2'd3, 32'd5, 32'd7, 32'd1, 32'd1);
      queue_req(rau_pkg::OP_SUB, 32'd1, 32'd0, 32'd1, 32'd1);
      queue_req(rau_pkg::OP_DIV, 32'd1, 32'd1, 32'd1, 32'd0);
      queue_req(rau_pkg::OP_NEG, 32'd1, 32'd0, 32'd1, 32'd0);
      queue_req(rau_pkg::OP_NEG, 32'd1, 32'd1, 32'd9, 32'd0);
      queue_req(rau_pkg::OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
      queue_req(rau_pkg::OP_SUB, 32'd4, 32'd6, 32'd2, 32'd3);
      queue_req(rau_pkg::OP_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
      queue_req(rau_pkg::OP_NEG, 32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd0);
      queue_req(rau_pkg::OP_NEG, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd0);
      queue_req(rau_pkg::OP_NEG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0);
      queue_req(rau_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000);
      queue_req(rau_pkg::OP_SUB, 32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'd1);
      queue_req(rau_pkg::OP_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
      queue_req(rau_pkg::OP_DIV, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_fffe,
                32'h7fff_ffff);
      queue_req(rau_pkg::OP_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff);
      queue_req(rau_pkg::OP_SUB, 32'hffff_ffff, 32'h8000_0000, 32'h8000_0000,
                32'hffff_ffff);
      drain();

      // sender pauses until every expected response is in, then resumes
      queue_random(480);
      fork
         begin
            repeat (600) @(posedge clock);
            hold_sender = 1'b1;
            while (expected_fracs.size() > 0 || req.valid) @(posedge clock);
            hold_sender = 1'b0;
         end
      join_none
      drain();

      send_idle_pct = 50;
      recv_idle_pct = 27;
      queue_random(480);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(490);
      drain();

      repeat (400) @(posedge clock);
      if (mismatches == 0 && expected_fracs.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // timeout: 1470 requests at the longest reduction each, with stalls, taken several times over
   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end
endmodule
